[rtl/gaes_pkg.sv]
package gaes_pkg;

  localparam int DATA_W   = 32;
  localparam int ENV_W    = 6;
  localparam int FACTOR_W = 17;
  localparam int COEF_W   = 18;
  localparam int FRAC_W   = 16;
  localparam int WIDE_W   = 38;

  localparam logic [FACTOR_W-1:0] DISCOUNT_RST    = 17'd64881;
  localparam logic [FACTOR_W-1:0] TRACE_DECAY_RST = 17'd62259;

  localparam logic signed [WIDE_W-1:0] SAT_HI = 38'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_LO = -38'sd2147483648;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_DISCOUNT    = 1'b0,
    REG_TRACE_DECAY = 1'b1
  } reg_idx_t;

  // factors handed to the datapath
  typedef struct packed {
    logic [FACTOR_W-1:0] discount;
    logic [COEF_W-1:0]   coef;      // round(gamma * lambda), Q2.16
  } cfg_t;

  // one item moving through the pipeline
  typedef struct packed {
    logic              valid;
    logic [ENV_W-1:0]  env;
    logic              in_range;  // env below ENV_COUNT: reads and writes state
    logic              keep;      // bootstrap and carry are used
    logic [DATA_W-1:0] reward;
    logic [DATA_W-1:0] value;
  } stage_t;

  // item that has left the MAC stage; entries of the write history
  typedef struct packed {
    logic              valid;
    logic              wr;
    logic [ENV_W-1:0]  env;
    logic [DATA_W-1:0] adv;
    logic [DATA_W-1:0] value;
  } wb_t;

  function automatic logic [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic [DATA_W-1:0] r;
    if (v > SAT_HI) begin
      r = 32'h7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'h8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/gae_advantage_scan_top.sv]
// Generalized advantage estimation, scanned backward in time over interleaved
// environments. Values Q16.16 signed, gamma/lambda unsigned Q1.16.
//
// Input stream (s_axis): one item per time step, newest step first per env.
//   tlast = final_step (env's last step: state taken as zero),
//   tuser = {episode_end, env_index}, tdata = {value_estimate, reward}.
// Output stream (m_axis): one item per input item, same order,
//   tdata = {return_value, advantage}, both saturated.
// APB port: reg 0 discount at 0x0, reg 1 trace_decay at 0x4; write only idle.
//
// Registers from accept to m_axis_tvalid: s1, s2, s3, wb0, output registers.
// One item per cycle when the output is not stalled, any env order. Per-env
// state sits in one 64-bit wide synchronous RAM read at accept and written
// after the MAC stage; three items in flight are forwarded from pipeline regs.
// Reset clears the pipeline valids and loads the register defaults; the RAM is
// not cleared, an env must start with a final_step item.
// Stall: all stages advance together; when the output item is held and not
// taken, s_axis_tready drops until it is.
module gae_advantage_scan_top #(
  parameter int ENV_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] reward, [63:32] value_estimate
  input  logic [6:0]  s_axis_tuser,   // [5:0] env_index, [6] episode_end
  input  logic        s_axis_tlast,   // final_step
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [31:0] advantage, [63:32] return_value
);

  localparam int AW = (ENV_COUNT > 1) ? $clog2(ENV_COUNT) : 1;

  gaes_pkg::cfg_t cfg;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [63:0]   rd_data, wr_data;
  logic [31:0]   out_adv, out_ret;

  gaes_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // per env: {running advantage, next value}
  gaes_state_mem #(
    .DEPTH (ENV_COUNT),
    .AW    (AW),
    .WIDTH (64)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  gaes_datapath #(
    .ENV_COUNT (ENV_COUNT),
    .AW        (AW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_env    (s_axis_tuser[5:0]),
    .in_final  (s_axis_tlast),
    .in_done   (s_axis_tuser[6]),
    .in_reward (s_axis_tdata[31:0]),
    .in_value  (s_axis_tdata[63:32]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_adv   (out_adv),
    .out_ret   (out_ret),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  assign m_axis_tdata = {out_ret, out_adv};

endmodule

[rtl/gaes_cfg.sv]
module gaes_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output gaes_pkg::cfg_t                 cfg
);

  logic [gaes_pkg::FACTOR_W-1:0] discount;
  logic [gaes_pkg::FACTOR_W-1:0] trace_decay;
  logic [gaes_pkg::COEF_W-1:0]   coef;
  logic [34:0]                   coef_prod;
  logic                          wr;
  gaes_pkg::reg_idx_t            idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = gaes_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      discount    <= gaes_pkg::DISCOUNT_RST;
      trace_decay <= gaes_pkg::TRACE_DECAY_RST;
    end else if (wr) begin
      unique case (idx)
        gaes_pkg::REG_DISCOUNT:    discount    <= pwdata[gaes_pkg::FACTOR_W-1:0];
        gaes_pkg::REG_TRACE_DECAY: trace_decay <= pwdata[gaes_pkg::FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  // combined factor, rounded to Q2.16; registered, so it follows the registers in the next cycle
  assign coef_prod = 35'(discount * trace_decay) + 35'd32768;

  always_ff @(posedge clk) begin
    coef <= coef_prod[33:16];
  end

  always_comb begin
    unique case (idx)
      gaes_pkg::REG_DISCOUNT:    prdata = 32'(discount);
      gaes_pkg::REG_TRACE_DECAY: prdata = 32'(trace_decay);
      default:                   prdata = '0;
    endcase
  end

  assign cfg.discount = discount;
  assign cfg.coef     = coef;

endmodule

[rtl/gaes_state_mem.sv]
module gaes_state_mem #(
  parameter int DEPTH  = 64,
  parameter int AW     = 6,
  parameter int WIDTH  = 64
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-address collision; the datapath forwards around it
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/gaes_datapath.sv]
module gaes_datapath #(
  parameter int ENV_COUNT = 64,
  parameter int AW        = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  input  gaes_pkg::cfg_t                  cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [gaes_pkg::ENV_W-1:0]      in_env,
  input  logic                            in_final,
  input  logic                            in_done,
  input  logic [gaes_pkg::DATA_W-1:0]     in_reward,
  input  logic [gaes_pkg::DATA_W-1:0]     in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [gaes_pkg::DATA_W-1:0]     out_adv,
  output logic [gaes_pkg::DATA_W-1:0]     out_ret,
  output logic                            rd_en,
  output logic [AW-1:0]                   rd_addr,
  input  logic [2*gaes_pkg::DATA_W-1:0]   rd_data,
  output logic                            wr_en,
  output logic [AW-1:0]                   wr_addr,
  output logic [2*gaes_pkg::DATA_W-1:0]   wr_data
);

  localparam int XW = (AW > gaes_pkg::ENV_W) ? AW : gaes_pkg::ENV_W;

  function automatic logic [AW-1:0] to_addr(input logic [gaes_pkg::ENV_W-1:0] e);
    logic [XW-1:0] x;
    x = XW'(e);
    return x[AW-1:0];
  endfunction

  logic            advance;
  logic            in_range_in;
  gaes_pkg::stage_t s1, s1_next, s2, s3;
  gaes_pkg::wb_t   wb0, wb0_next, wb1, wb2;

  logic [gaes_pkg::DATA_W-1:0] vn_sel, vn, s2_madv, s3_madv, carry_sel, carry;
  logic signed [49:0]          prod_g, s2_prod, prod_r;
  logic signed [33:0]          rnd_g;
  logic signed [35:0]          delta, s3_delta;
  logic signed [50:0]          mac;
  logic signed [53:0]          acc;
  logic [gaes_pkg::DATA_W-1:0] adv_sat, ret_sat;
  logic signed [32:0]          ret_full;

  // all stages move together; the output register is the only place that waits
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  assign in_range_in = 32'(in_env) < ENV_COUNT;
  assign rd_en       = advance;
  assign rd_addr     = to_addr(in_env);

  always_comb begin
    s1_next.valid    = in_valid;
    s1_next.env      = in_env;
    s1_next.in_range = in_range_in;
    s1_next.keep     = in_range_in && !in_final && !in_done;
    s1_next.reward   = in_reward;
    s1_next.value    = in_value;
  end

  // stage 1: next value, newest writer first (stage 2, stage 3, last written)
  always_comb begin
    priority if (s2.valid && s2.in_range && s2.env == s1.env) begin
      vn_sel = s2.value;
    end else if (s3.valid && s3.in_range && s3.env == s1.env) begin
      vn_sel = s3.value;
    end else if (wb0.wr && wb0.env == s1.env) begin
      vn_sel = wb0.value;
    end else begin
      vn_sel = rd_data[gaes_pkg::DATA_W-1:0];
    end
  end

  assign vn     = s1.keep ? vn_sel : '0;
  assign prod_g = $signed({1'b0, cfg.discount}) * $signed(vn);

  // stage 2: delta, exact
  assign prod_r = s2_prod + 50'sd32768;
  assign rnd_g  = prod_r[49:16];
  assign delta  = $signed({{4{s2.reward[31]}}, s2.reward}) + 36'(rnd_g)
                  - $signed({{4{s2.value[31]}}, s2.value});

  // stage 3: carry from the three items that left after this one read memory
  always_comb begin
    priority if (wb0.wr && wb0.env == s3.env) begin
      carry_sel = wb0.adv;
    end else if (wb1.wr && wb1.env == s3.env) begin
      carry_sel = wb1.adv;
    end else if (wb2.wr && wb2.env == s3.env) begin
      carry_sel = wb2.adv;
    end else begin
      carry_sel = s3_madv;
    end
  end

  assign carry = s3.keep ? carry_sel : '0;
  assign mac   = $signed({1'b0, cfg.coef}) * $signed(carry);
  // rounding constant and delta folded into one sum before the shift
  assign acc   = 54'(mac) + $signed({s3_delta, 16'd0}) + 54'sd32768;
  assign adv_sat = gaes_pkg::sat32(acc[53:16]);

  always_comb begin
    wb0_next.valid = s3.valid;
    wb0_next.wr    = s3.valid && s3.in_range;
    wb0_next.env   = s3.env;
    wb0_next.adv   = adv_sat;
    wb0_next.value = s3.value;
  end

  assign wr_en   = advance && s3.valid && s3.in_range;
  assign wr_addr = to_addr(s3.env);
  assign wr_data = {adv_sat, s3.value};

  // output stage: return from the registered advantage
  assign ret_full = $signed({wb0.adv[31], wb0.adv}) + $signed({wb0.value[31], wb0.value});
  assign ret_sat  = gaes_pkg::sat32(38'(ret_full));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid  <= 1'b0;
      s2.valid  <= 1'b0;
      s3.valid  <= 1'b0;
      wb0.valid <= 1'b0;
      wb0.wr    <= 1'b0;
      wb1.valid <= 1'b0;
      wb1.wr    <= 1'b0;
      wb2.valid <= 1'b0;
      wb2.wr    <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1        <= s1_next;
      s2        <= s1;
      s2_prod   <= prod_g;
      s2_madv   <= rd_data[2*gaes_pkg::DATA_W-1:gaes_pkg::DATA_W];
      s3        <= s2;
      s3_delta  <= delta;
      s3_madv   <= s2_madv;
      wb0       <= wb0_next;
      wb1       <= wb0;
      wb2       <= wb1;
      out_valid <= wb0.valid;
      out_adv   <= wb0.adv;
      out_ret   <= ret_sat;
    end
  end

endmodule

[rtl/gaes_checker.sv]
module gaes_checker (
  input logic        clk,
  input logic        rst,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  logic s_acc, disc_wr;

  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign disc_wr = psel && penable && pwrite && pready && !paddr[2];

  // no result may come out of reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a held result keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // input is taken whenever the output side is not blocked
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !(m_axis_tvalid && !m_axis_tready) |-> s_axis_tready)
    else $error("input stalled without output backpressure");

  // result shows once the item has passed s1, s2, s3 and wb0 while the receiver keeps taking
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_acc ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
    |=> m_axis_tvalid)
    else $error("result missing after pipeline latency");

  // discount reads back what was written
  a_cfg_read: assert property (@(posedge clk) disable iff (rst)
    $past(disc_wr) && !$past(rst) && !paddr[2] |-> prdata == {15'd0, $past(pwdata[16:0])})
    else $error("discount readback mismatch");

endmodule

bind gae_advantage_scan_top gaes_checker u_gaes_checker (.*);
